// ===== rtl/aes_pkg.sv =====
// Shared types, S-box table and GF(2^8) helpers for the AES block encryptor.
package aes_pkg;

  typedef logic [127:0] block_t;

  // Step selection for the shared round unit.
  typedef struct packed {
    logic first;  // key addition only
    logic last;   // final round, no MixColumns
  } round_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
    8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
    8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
    8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
    8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
    8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
    8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
    8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
    8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
    8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
    8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
    8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
    8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
    8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
    8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
    8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
    8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
    8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
    8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
    8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
    8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
    8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
    8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
    8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
    8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
    8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
    8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
    8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
    8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
    8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
  };

  localparam logic [7:0] GF_POLY = 8'h1B;

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

endpackage

// ===== rtl/aes_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  round_index;
  logic [63:0] data_high;
  logic [63:0] data_low;

  modport source (output valid, kind, round_index, data_high, data_low, input ready);
  modport sink (input valid, kind, round_index, data_high, data_low, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;

  modport source (output valid, cipher_high, cipher_low, input ready);
  modport sink (input valid, cipher_high, cipher_low, output ready);
endinterface

// ===== rtl/aes_key_store.sv =====
// Round key memory: one write port, one registered read port.
module aes_key_store
  import aes_pkg::*;
#(
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  block_t                   wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output block_t                   rd_data
);

  block_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/aes_round.sv =====
// Shared round unit: SubBytes, ShiftRows, MixColumns and AddRoundKey.
module aes_round
  import aes_pkg::*;
(
  input  block_t     state,
  input  block_t     round_key,
  input  round_ctl_t ctl,
  output block_t     result
);

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  block_t     mixed;
  block_t     shifted;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state[127 - 8*i -: 8];
    end
    // byte 4*c+r is row r, column c; row r rotates left by r columns
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c + r] = SBOX[s[4*((c + r) % 4) + r]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] all_x;
      all_x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ all_x ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ all_x ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ all_x ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ all_x ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      shifted[127 - 8*i -: 8] = t[i];
      mixed[127 - 8*i -: 8]   = m[i];
    end
    if (ctl.first) begin
      result = state ^ round_key;
    end else if (ctl.last) begin
      result = shifted ^ round_key;
    end else begin
      result = mixed ^ round_key;
    end
  end

endmodule

// ===== rtl/aes_block_encrypt_top.sv =====
// AES block encryptor with externally loaded round keys.
//
// Request channel (req): kind 0 loads round key slot round_index (0..ROUNDS)
// from data_high/data_low; slots above ROUNDS are dropped.
// kind 1 encrypts the 128-bit block data_high/data_low with the stored keys.
// Response channel (rsp): one transaction per encrypt, none per load.
//
// An encrypt runs the initial key addition plus ROUNDS rounds through a
// single round unit, one round per cycle, save that the last round waits
// while the output register is full. The ciphertext is registered when the
// last round is done; req ready is low while an encrypt runs and comes back
// only after the last round is registered, so a new encrypt is taken only
// once the previous one has finished all its rounds.
// The result sits in an output register, so the next request is taken while
// it waits. If rsp is stalled when the next encrypt finishes, that encrypt
// holds in its last round until the output register frees up.
// All keys used by an encrypt must have been loaded since reset.
// Reset (rst, synchronous) clears the sequencer and the response valid; the
// key memory keeps its contents.
module aes_block_encrypt_top
  import aes_pkg::*;
#(
  parameter int ROUNDS = 10
) (
  input logic      clk,
  input logic      rst,
  aes_in_if.sink   req,
  aes_out_if.source rsp
);

  localparam int DEPTH = ROUNDS + 1;
  localparam int CW    = $clog2(DEPTH);
  localparam logic [CW-1:0] LAST = CW'(ROUNDS);

  logic          busy;
  logic [CW-1:0] cnt;
  block_t        state;
  logic          out_valid;
  block_t        cipher;

  logic          take;
  logic          start;
  logic          load_en;
  logic          step;
  logic          fire_last;
  logic          rd_en;
  logic [CW-1:0] rd_addr;
  block_t        key;
  block_t        round_out;
  round_ctl_t    ctl;

  assign req.ready = !busy;
  assign take      = req.valid && !busy;
  assign start     = take && req.kind;
  assign load_en   = take && !req.kind && (32'(req.round_index) <= ROUNDS);

  assign step      = busy && (cnt != LAST);
  assign fire_last = busy && (cnt == LAST) && (!out_valid || rsp.ready);

  // fetch the key for the next cycle's round
  assign rd_en   = start || step;
  assign rd_addr = start ? '0 : cnt + 1'b1;

  assign ctl.first = (cnt == '0);
  assign ctl.last  = (cnt == LAST);

  aes_key_store #(
    .DEPTH (DEPTH)
  ) u_key_store (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (req.round_index[CW-1:0]),
    .wr_data ({req.data_high, req.data_low}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (key)
  );

  aes_round u_round (
    .state     (state),
    .round_key (key),
    .ctl       (ctl),
    .result    (round_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (step) begin
        cnt <= cnt + 1'b1;
      end else if (fire_last) begin
        busy <= 1'b0;
      end
      if (fire_last) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      state <= {req.data_high, req.data_low};
    end else if (step) begin
      state <= round_out;
    end
    if (fire_last) begin
      cipher <= round_out;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.cipher_high = cipher[127:64];
  assign rsp.cipher_low  = cipher[63:0];

endmodule
